FILE: hdl/packed_triangle_index_convert_defines.svh
// ----------------------------------------------------------------------------
// Packed triangle index converter: assertion macros
// Shared assertion shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKED_TRIANGLE_INDEX_CONVERT_DEFINES_SVH
`define PACKED_TRIANGLE_INDEX_CONVERT_DEFINES_SVH

// same-cycle implication
`define PTIC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptic assertion failed");

// next-cycle implication
`define PTIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptic assertion failed");

`endif

FILE: hdl/ptic_pkg.sv
// ----------------------------------------------------------------------------
// Packed triangle index converter: package
// Widths, microcode word layout, control codes and the microcode ROM.
// ----------------------------------------------------------------------------
package ptic_pkg;

  localparam int IDX_W   = 24;
  localparam int DIM_W   = 13;
  localparam int PROD_W  = 2 * DIM_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int CNT_W   = 5;
  localparam int UPC_W   = 5;
  localparam int DIM_MAX = (1 << DIM_W) - 1;

  localparam int unsigned PTIC_MAX_DIM_DEF = 4096;
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

  localparam logic [CNT_W-1:0] DIV_STEPS_M1    = CNT_W'(IDX_W - 1);
  localparam logic [CNT_W-1:0] SEARCH_STEPS_M1 = CNT_W'(DIM_W - 1);

  // datapath operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_START  = 4'd1;
  localparam logic [3:0] OP_DIV    = 4'd2;
  localparam logic [3:0] OP_LOHI   = 4'd3;
  localparam logic [3:0] OP_MUL    = 4'd4;
  localparam logic [3:0] OP_TRI    = 4'd5;
  localparam logic [3:0] OP_ADDHL  = 4'd6;
  localparam logic [3:0] OP_TOTAL  = 4'd7;
  localparam logic [3:0] OP_SEARCH = 4'd8;
  localparam logic [3:0] OP_FULL   = 4'd9;
  localparam logic [3:0] OP_RANGE  = 4'd10;
  localparam logic [3:0] OP_DONE   = 4'd11;

  // multiplier operand A
  localparam logic [1:0] MA_LO    = 2'd0;
  localparam logic [1:0] MA_TRIAL = 2'd1;
  localparam logic [1:0] MA_COL   = 2'd2;
  localparam logic [1:0] MA_DEFF  = 2'd3;

  // multiplier operand B
  localparam logic [1:0] MB_DM1  = 2'd0;
  localparam logic [1:0] MB_AM1  = 2'd1;
  localparam logic [1:0] MB_DEFF = 2'd2;

  // product destination
  localparam logic DST_P1 = 1'b0;
  localparam logic DST_P2 = 1'b1;

  // jump conditions
  localparam logic [2:0] C_NONE   = 3'd0;
  localparam logic [2:0] C_ALWAYS = 3'd1;
  localparam logic [2:0] C_ACT1   = 3'd2;
  localparam logic [2:0] C_INV    = 3'd3;
  localparam logic [2:0] C_CNT    = 3'd4;

  // program addresses
  localparam logic [UPC_W-1:0] A_DIV    = 5'd2;
  localparam logic [UPC_W-1:0] A_ACT1   = 5'd9;
  localparam logic [UPC_W-1:0] A_SEARCH = 5'd12;
  localparam logic [UPC_W-1:0] A_RANGE  = 5'd20;
  localparam logic [UPC_W-1:0] A_DONE   = 5'd21;

  typedef struct packed {
    logic [3:0]       op;
    logic [1:0]       ma;
    logic [1:0]       mb;
    logic             dst;
    logic [2:0]       cond;
    logic [UPC_W-1:0] target;
  } ptic_uword_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             invalid;
  } ptic_res_t;

  function automatic ptic_uword_t ptic_uw(logic [3:0] op, logic [1:0] ma, logic [1:0] mb,
                                          logic dst, logic [2:0] cond,
                                          logic [UPC_W-1:0] target);
    ptic_uword_t w;
    w.op     = op;
    w.ma     = ma;
    w.mb     = mb;
    w.dst    = dst;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ptic_uword_t ptic_urom(logic [UPC_W-1:0] addr);
    ptic_uword_t w;
    unique case (addr)
      // shared entry, split on action
      5'd0:  w = ptic_uw(OP_START,  MA_LO,    MB_DM1,  DST_P1, C_ACT1,   A_ACT1);
      // full -> packed
      5'd1:  w = ptic_uw(OP_NOP,    MA_LO,    MB_DM1,  DST_P1, C_INV,    A_DONE);
      5'd2:  w = ptic_uw(OP_DIV,    MA_LO,    MB_DM1,  DST_P1, C_CNT,    A_DIV);
      5'd3:  w = ptic_uw(OP_LOHI,   MA_LO,    MB_DM1,  DST_P1, C_NONE,   A_DONE);
      5'd4:  w = ptic_uw(OP_NOP,    MA_LO,    MB_DM1,  DST_P1, C_INV,    A_DONE);
      5'd5:  w = ptic_uw(OP_MUL,    MA_LO,    MB_DM1,  DST_P1, C_NONE,   A_DONE);
      5'd6:  w = ptic_uw(OP_MUL,    MA_LO,    MB_AM1,  DST_P2, C_NONE,   A_DONE);
      5'd7:  w = ptic_uw(OP_TRI,    MA_LO,    MB_DM1,  DST_P1, C_NONE,   A_DONE);
      5'd8:  w = ptic_uw(OP_ADDHL,  MA_LO,    MB_DM1,  DST_P1, C_ALWAYS, A_RANGE);
      // packed -> full
      5'd9:  w = ptic_uw(OP_MUL,    MA_DEFF,  MB_DM1,  DST_P1, C_INV,    A_DONE);
      5'd10: w = ptic_uw(OP_TOTAL,  MA_LO,    MB_DM1,  DST_P1, C_NONE,   A_DONE);
      5'd11: w = ptic_uw(OP_NOP,    MA_LO,    MB_DM1,  DST_P1, C_INV,    A_DONE);
      5'd12: w = ptic_uw(OP_MUL,    MA_TRIAL, MB_DM1,  DST_P1, C_NONE,   A_DONE);
      5'd13: w = ptic_uw(OP_MUL,    MA_TRIAL, MB_AM1,  DST_P2, C_NONE,   A_DONE);
      5'd14: w = ptic_uw(OP_SEARCH, MA_LO,    MB_DM1,  DST_P1, C_CNT,    A_SEARCH);
      5'd15: w = ptic_uw(OP_MUL,    MA_COL,   MB_DM1,  DST_P1, C_NONE,   A_DONE);
      5'd16: w = ptic_uw(OP_MUL,    MA_COL,   MB_AM1,  DST_P2, C_NONE,   A_DONE);
      5'd17: w = ptic_uw(OP_TRI,    MA_LO,    MB_DM1,  DST_P1, C_NONE,   A_DONE);
      5'd18: w = ptic_uw(OP_MUL,    MA_COL,   MB_DEFF, DST_P1, C_NONE,   A_DONE);
      5'd19: w = ptic_uw(OP_FULL,   MA_LO,    MB_DM1,  DST_P1, C_NONE,   A_DONE);
      // common tail
      5'd20: w = ptic_uw(OP_RANGE,  MA_LO,    MB_DM1,  DST_P1, C_NONE,   A_DONE);
      5'd21: w = ptic_uw(OP_DONE,   MA_LO,    MB_DM1,  DST_P1, C_NONE,   A_DONE);
      default: w = ptic_uw(OP_DONE, MA_LO,    MB_DM1,  DST_P1, C_NONE,   A_DONE);
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/ptic_core.sv
// ----------------------------------------------------------------------------
// Packed triangle index converter: microcoded core
// Step counter, microcode ROM and a datapath with one divider step, one
// registered 13x13 multiplier and one 27-bit adder.
// ----------------------------------------------------------------------------
`include "packed_triangle_index_convert_defines.svh"

module ptic_core #(
  parameter int unsigned MAX_DIMENSION = ptic_pkg::PTIC_MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic                       act_i,
  input  logic [ptic_pkg::IDX_W-1:0] idx_i,
  input  logic [ptic_pkg::DIM_W-1:0] cfg_dim_i,
  input  logic                       out_free_i,
  output logic                       busy_o,
  output logic                       done_o,
  output ptic_pkg::ptic_res_t        res_o
);
  import ptic_pkg::*;

  localparam int unsigned SAT_DIM = (MAX_DIMENSION > DIM_MAX) ? DIM_MAX : MAX_DIMENSION;
  localparam logic [DIM_W-1:0] SAT_D = SAT_DIM[DIM_W-1:0];

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;

  logic             act_r, act_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [DIM_W-1:0] d_r, d_nxt;
  logic [DIM_W-1:0] dm1_r, dm1_nxt;
  logic [DIM_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] quo_r, quo_nxt;
  logic [DIM_W-1:0] lo_r, lo_nxt;
  logic [DIM_W-1:0] hi_r, hi_nxt;
  logic [DIM_W-1:0] c_r, c_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0] p1_r, p1_nxt;
  logic [PROD_W-1:0] p2_r, p2_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             inv_r, inv_nxt;

  ptic_uword_t      uw;
  logic [DIM_W-1:0] deff;
  logic [DIM_W-1:0] trial;
  logic [DIM_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [DIM_W:0]   div_sh;
  logic             div_ge;
  logic [PROD_W-1:0] tri_val;
  logic             jump;

  assign uw    = ptic_urom(upc_r);
  assign deff  = (cfg_dim_i > SAT_D) ? SAT_D : cfg_dim_i;
  assign trial = c_r | (DIM_W'(1) << cnt_r[3:0]);

  always_comb begin
    unique case (uw.ma)
      MA_LO:    mul_a = lo_r;
      MA_TRIAL: mul_a = trial;
      MA_COL:   mul_a = c_r;
      MA_DEFF:  mul_a = d_r;
      default:  mul_a = lo_r;
    endcase
    unique case (uw.mb)
      MB_DM1:  mul_b = dm1_r;
      MB_AM1:  mul_b = mul_a - DIM_W'(1);
      MB_DEFF: mul_b = d_r;
      default: mul_b = dm1_r;
    endcase
  end

  assign prod    = mul_a * mul_b;
  // restoring divider: shift one dividend bit in per step
  assign div_sh  = {rem_r, quo_r[IDX_W-1]};
  assign div_ge  = div_sh >= {1'b0, d_r};
  // columns 0..n-1 hold n*(d-1) - n*(n-1)/2 entries
  assign tri_val = p1_r - {1'b0, p2_r[PROD_W-1:1]};

  always_comb begin
    unique case (uw.cond)
      C_NONE:   jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_ACT1:   jump = act_r;
      C_INV:    jump = inv_r;
      C_CNT:    jump = cnt_r != '0;
      default:  jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    act_nxt  = act_r;
    idx_nxt  = idx_r;
    d_nxt    = d_r;
    dm1_nxt  = dm1_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    c_nxt    = c_r;
    cnt_nxt  = cnt_r;
    p1_nxt   = p1_r;
    p2_nxt   = p2_r;
    acc_nxt  = acc_r;
    inv_nxt  = inv_r;
    done_o   = 1'b0;

    if (start_i) begin
      act_nxt  = act_i;
      idx_nxt  = idx_i;
      upc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      upc_nxt = jump ? uw.target : upc_r + UPC_W'(1);
      unique case (uw.op)
        OP_NOP: begin
        end
        OP_START: begin
          d_nxt   = deff;
          dm1_nxt = deff - DIM_W'(1);
          rem_nxt = '0;
          quo_nxt = idx_r;
          cnt_nxt = DIV_STEPS_M1;
          inv_nxt = act_r ? (deff < DIM_W'(2)) : (deff == '0);
        end
        OP_DIV: begin
          rem_nxt = div_ge ? DIM_W'(div_sh - {1'b0, d_r}) : div_sh[DIM_W-1:0];
          quo_nxt = {quo_r[IDX_W-2:0], div_ge};
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        OP_LOHI: begin
          // quotient is the column, remainder the row
          inv_nxt = (quo_r >= IDX_W'(d_r)) || (IDX_W'(rem_r) == quo_r);
          if (IDX_W'(rem_r) < quo_r) begin
            lo_nxt = rem_r;
            hi_nxt = quo_r[DIM_W-1:0];
          end else begin
            lo_nxt = quo_r[DIM_W-1:0];
            hi_nxt = rem_r;
          end
        end
        OP_MUL: begin
          if (uw.dst == DST_P2) begin
            p2_nxt = prod;
          end else begin
            p1_nxt = prod;
          end
        end
        OP_TRI: begin
          acc_nxt = ACC_W'(tri_val);
        end
        OP_ADDHL: begin
          acc_nxt = acc_r + ACC_W'(hi_r) - ACC_W'(lo_r) - ACC_W'(1);
        end
        OP_TOTAL: begin
          inv_nxt = PROD_W'(idx_r) >= {1'b0, p1_r[PROD_W-1:1]};
          c_nxt   = '0;
          cnt_nxt = SEARCH_STEPS_M1;
        end
        OP_SEARCH: begin
          // binary search for the last column starting at or before idx
          if (trial <= dm1_r && tri_val <= PROD_W'(idx_r)) begin
            c_nxt = trial;
          end
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        OP_FULL: begin
          acc_nxt = ACC_W'(p1_r) + ACC_W'(c_r) + ACC_W'(1) + ACC_W'(idx_r) - acc_r;
        end
        OP_RANGE: begin
          inv_nxt = inv_r || (acc_r[ACC_W-1:IDX_W] != '0);
        end
        OP_DONE: begin
          if (out_free_i) begin
            done_o   = 1'b1;
            busy_nxt = 1'b0;
          end
          upc_nxt = upc_r;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  assign busy_o        = busy_r;
  assign res_o.invalid = inv_r;
  assign res_o.index   = inv_r ? '0 : acc_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    idx_r <= idx_nxt;
    d_r   <= d_nxt;
    dm1_r <= dm1_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    c_r   <= c_nxt;
    cnt_r <= cnt_nxt;
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    acc_r <= acc_nxt;
    inv_r <= inv_nxt;
  end

  `PTIC_ASSERT_IMPL(a_no_start_busy, start_i, !busy_r)
  `PTIC_ASSERT_IMPL(a_upc_in_program, busy_r, upc_r <= A_DONE)
  `PTIC_ASSERT_NEXT(a_div_rem, busy_r && !start_i && uw.op == OP_DIV && cnt_r == '0, rem_r < d_r)
  `PTIC_ASSERT_NEXT(a_search_col, busy_r && !start_i && uw.op == OP_SEARCH, c_r <= dm1_r)
  `PTIC_ASSERT_NEXT(a_done_idle, done_o, !busy_r)

endmodule

FILE: hdl/packed_triangle_index_convert.sv
// ----------------------------------------------------------------------------
// Packed triangle index converter: top level
// Converts between a full column-major matrix index and a packed
// strictly-lower-triangle index, in either direction.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write matrix_dimension with cfg_valid/cfg_ready; write only while
//            idle. cfg_ready is always high.
//   in_*   : one transfer per item (in_valid high, in_stall low). in_action 0
//            maps a full index to a packed index, 1 maps packed back to full.
//   out_*  : one result per item, out_invalid set with out_index_out zero when
//            the input is on the diagonal or out of range.
// Sequencing: a microcode program runs each item; action 0 runs a 24-step
//   divider loop and action 1 runs 13 rounds of three steps in the column
//   search. A zero dimension or a packed index outside the triangle jumps
//   straight to the done step; diagonal or out-of-range full indexes still
//   run the divider. One item is in flight at a time; in_stall is high while
//   it runs.
// The output register holds one finished result, so a new item is taken
//   while that result waits. When out_stall keeps a result pending, the next
//   item finishes its program and parks on its last step.
// Reset: synchronous, active low; clears the sequencer and the output valid,
//   and sets matrix_dimension to 4096.
// ----------------------------------------------------------------------------
module packed_triangle_index_convert #(
  parameter int unsigned MAX_DIMENSION = ptic_pkg::PTIC_MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ptic_pkg::DIM_W-1:0] cfg_matrix_dimension,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [ptic_pkg::IDX_W-1:0] in_index_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ptic_pkg::IDX_W-1:0] out_index_out,
  output logic                       out_invalid
);
  import ptic_pkg::*;

  logic [DIM_W-1:0] dim_r, dim_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;
  logic             out_invalid_r, out_invalid_nxt;

  logic      busy;
  logic      done;
  logic      start;
  logic      out_free;
  ptic_res_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign out_free  = !out_valid_r || !out_stall;

  ptic_core #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .act_i      (in_action),
    .idx_i      (in_index_in),
    .cfg_dim_i  (dim_r),
    .out_free_i (out_free),
    .busy_o     (busy),
    .done_o     (done),
    .res_o      (res)
  );

  always_comb begin
    dim_nxt         = dim_r;
    out_valid_nxt   = out_valid_r;
    out_index_nxt   = out_index_r;
    out_invalid_nxt = out_invalid_r;
    if (cfg_valid && cfg_ready) begin
      dim_nxt = cfg_matrix_dimension;
    end
    if (done) begin
      out_valid_nxt   = 1'b1;
      out_index_nxt   = res.index;
      out_invalid_nxt = res.invalid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r       <= DIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      dim_r       <= dim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_index_r   <= out_index_nxt;
    out_invalid_r <= out_invalid_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_index_out = out_index_r;
  assign out_invalid   = out_invalid_r;

endmodule
